[design/ads_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_pkg: shared types and constants for adaptive differential steering
// Control word format, microprogram ROM, register indexes and fixed-point
// constants.
// ----------------------------------------------------------------------------
package ads_pkg;

  // register file
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THR = 3'd0,
    REG_IMG_WIDTH = 3'd1,
    REG_FRAC_MIN  = 3'd2,
    REG_FRAC_MAX  = 3'd3,
    REG_SPD_NEAR  = 3'd4,
    REG_SPD_FAR   = 3'd5,
    REG_GAIN_NEAR = 3'd6,
    REG_GAIN_FAR  = 3'd7
  } reg_idx_t;

  // divider
  localparam int DIV_W = 32;
  localparam int DVS_W = 16;
  localparam int DIV_STEPS = DIV_W / 2;

  // fixed point
  localparam logic [15:0] Q15_ONE   = 16'd32768;
  localparam logic [12:0] BETA_NEAR = 13'd4915;
  localparam logic [14:0] DECAY_Q15 = 15'd27853;
  localparam logic [6:0]  POWER_MAX = 7'd100;
  localparam int FILT_W  = 24;
  localparam int ALPHA_W = 16;
  localparam int BETA_W  = 15;
  localparam int VB_W    = 22;
  localparam int GAIN_W  = 23;
  localparam int PROD_W  = 40;
  localparam int EMA_W   = 41;

  // microprogram
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [4:0] {
    OP_NOP     = 5'd0,
    OP_FRAC    = 5'd1,
    OP_ALPHA   = 5'd2,
    OP_ALPHA_Q = 5'd3,
    OP_EX      = 5'd4,
    OP_VB      = 5'd5,
    OP_GAIN    = 5'd6,
    OP_BETA    = 5'd7,
    OP_STEER   = 5'd8,
    OP_SIDE_L  = 5'd9,
    OP_SIDE_R  = 5'd10,
    OP_EMA_L1  = 5'd11,
    OP_EMA_L2  = 5'd12,
    OP_EMA_R1  = 5'd13,
    OP_EMA_R2  = 5'd14,
    OP_DECAY_L = 5'd15,
    OP_DECAY_R = 5'd16,
    OP_OUT     = 5'd17
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_REJECT   = 3'd2,
    COND_DIV_BUSY = 3'd3,
    COND_NO_DIV   = 3'd4,
    COND_OUT_HELD = 3'd5
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ucw_t;

  localparam step_t ST_CHECK      = 5'd0;
  localparam step_t ST_FRAC       = 5'd1;
  localparam step_t ST_FRAC_WAIT  = 5'd2;
  localparam step_t ST_ALPHA      = 5'd3;
  localparam step_t ST_ALPHA_WAIT = 5'd4;
  localparam step_t ST_ALPHA_Q    = 5'd5;
  localparam step_t ST_EX         = 5'd6;
  localparam step_t ST_VB         = 5'd7;
  localparam step_t ST_GAIN       = 5'd8;
  localparam step_t ST_BETA       = 5'd9;
  localparam step_t ST_EX_WAIT    = 5'd10;
  localparam step_t ST_STEER      = 5'd11;
  localparam step_t ST_SIDE_L     = 5'd12;
  localparam step_t ST_SIDE_R     = 5'd13;
  localparam step_t ST_EMA_L1     = 5'd14;
  localparam step_t ST_EMA_L2     = 5'd15;
  localparam step_t ST_EMA_R1     = 5'd16;
  localparam step_t ST_EMA_R2     = 5'd17;
  localparam step_t ST_DECAY_L    = 5'd18;
  localparam step_t ST_DECAY_R    = 5'd19;
  localparam step_t ST_OUT        = 5'd20;

  function automatic ucw_t uw(input op_t op, input cond_t cond, input step_t target,
                              input logic last);
    ucw_t w;
    w.op = op;
    w.cond = cond;
    w.target = target;
    w.last = last;
    return w;
  endfunction

  function automatic ucw_t ucode(input step_t s);
    ucw_t w;
    unique case (s)
      ST_CHECK:      w = uw(OP_NOP,     COND_REJECT,   ST_DECAY_L,    1'b0);
      ST_FRAC:       w = uw(OP_FRAC,    COND_NONE,     ST_CHECK,      1'b0);
      ST_FRAC_WAIT:  w = uw(OP_NOP,     COND_DIV_BUSY, ST_FRAC_WAIT,  1'b0);
      ST_ALPHA:      w = uw(OP_ALPHA,   COND_NO_DIV,   ST_EX,         1'b0);
      ST_ALPHA_WAIT: w = uw(OP_NOP,     COND_DIV_BUSY, ST_ALPHA_WAIT, 1'b0);
      ST_ALPHA_Q:    w = uw(OP_ALPHA_Q, COND_NONE,     ST_CHECK,      1'b0);
      ST_EX:         w = uw(OP_EX,      COND_NONE,     ST_CHECK,      1'b0);
      ST_VB:         w = uw(OP_VB,      COND_NONE,     ST_CHECK,      1'b0);
      ST_GAIN:       w = uw(OP_GAIN,    COND_NONE,     ST_CHECK,      1'b0);
      ST_BETA:       w = uw(OP_BETA,    COND_NONE,     ST_CHECK,      1'b0);
      ST_EX_WAIT:    w = uw(OP_NOP,     COND_DIV_BUSY, ST_EX_WAIT,    1'b0);
      ST_STEER:      w = uw(OP_STEER,   COND_NONE,     ST_CHECK,      1'b0);
      ST_SIDE_L:     w = uw(OP_SIDE_L,  COND_NONE,     ST_CHECK,      1'b0);
      ST_SIDE_R:     w = uw(OP_SIDE_R,  COND_NONE,     ST_CHECK,      1'b0);
      ST_EMA_L1:     w = uw(OP_EMA_L1,  COND_NONE,     ST_CHECK,      1'b0);
      ST_EMA_L2:     w = uw(OP_EMA_L2,  COND_NONE,     ST_CHECK,      1'b0);
      ST_EMA_R1:     w = uw(OP_EMA_R1,  COND_NONE,     ST_CHECK,      1'b0);
      ST_EMA_R2:     w = uw(OP_EMA_R2,  COND_ALWAYS,   ST_OUT,        1'b0);
      ST_DECAY_L:    w = uw(OP_DECAY_L, COND_NONE,     ST_CHECK,      1'b0);
      ST_DECAY_R:    w = uw(OP_DECAY_R, COND_NONE,     ST_CHECK,      1'b0);
      ST_OUT:        w = uw(OP_OUT,     COND_OUT_HELD, ST_OUT,        1'b1);
      default:       w = uw(OP_NOP,     COND_NONE,     ST_CHECK,      1'b1);
    endcase
    return w;
  endfunction

  // filter Q8.16 -> power, rounded half up, capped
  function automatic logic [6:0] filt_out(input logic [FILT_W-1:0] f);
    logic [FILT_W:0] t;
    logic [8:0] r;
    t = (FILT_W + 1)'(f) + (FILT_W + 1)'(32768);
    r = t[FILT_W:16];
    if (r > 9'(POWER_MAX)) begin
      return POWER_MAX;
    end
    return r[6:0];
  endfunction

endpackage
`default_nettype wire

[design/ads_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ads_div: radix-4 restoring divider
// Unsigned 32 / 16 bit division, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ads_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ads_pkg::DIV_W-1:0] dividend,
  input  wire logic [ads_pkg::DVS_W-1:0] divisor,
  output logic                           busy,
  output logic [ads_pkg::DIV_W-1:0]      quotient
);
  import ads_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;

  logic [DVS_W:0]   t1, t2;
  logic [DVS_W-1:0] r1, r2;
  logic             b1, b2;

  always_comb begin
    t1 = {rem_r, dvd_r[DIV_W-1]};
    if (t1 >= {1'b0, dvs_r}) begin
      r1 = DVS_W'(t1 - {1'b0, dvs_r});
      b1 = 1'b1;
    end else begin
      r1 = t1[DVS_W-1:0];
      b1 = 1'b0;
    end
    t2 = {r1, dvd_r[DIV_W-2]};
    if (t2 >= {1'b0, dvs_r}) begin
      r2 = DVS_W'(t2 - {1'b0, dvs_r});
      b2 = 1'b1;
    end else begin
      r2 = t2[DVS_W-1:0];
      b2 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-3:0], b1, b2};
      rem_r <= r2;
    end
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule
`default_nettype wire

[design/adaptive_differential_steering.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_differential_steering: per-frame differential drive steering
// Turns one detection record per frame into smoothed left/right motor powers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one detection record per frame. A transfer happens
//   when in_valid is high and in_stall is low. in_stall is high while the
//   sequencer works on a record.
//   Result channel (out_*): one result per record, held in an output
//   register; out_stall from the receiver holds it. While a result waits,
//   the next record is taken and computed; its program parks on the final
//   step until the output register frees up.
//   Config port (cfg_*): write-only, one register per cycle on cfg_we;
//   write only while no record is in flight.
// Timing:
//   A ROM microprogram steps a plain datapath, one control word per cycle.
//   A rejected frame decays both filters; a tracked frame runs two
//   divisions, or three when the size fraction lies inside the band, on the
//   shared radix-4 divider.
//   The next record is taken in the cycle after the result loads.
// Reset:
//   Synchronous, active low. Clears both filters, loads register defaults,
//   drops out_valid and idles the sequencer.
// ----------------------------------------------------------------------------
module adaptive_differential_steering #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_target_found,
  input  wire logic signed [15:0]              in_match_score,
  input  wire logic [COORD_BITS-1:0]           in_target_column,
  input  wire logic [COORD_BITS-1:0]           in_target_width,
  input  wire logic [3:0]                      in_pressed_key,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [6:0]                           out_left_power,
  output logic [6:0]                           out_right_power,
  output logic                                 out_override_active,
  output logic [3:0]                           out_override_key,
  // config port
  input  wire logic                            cfg_we,
  input  wire logic [ads_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ads_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ads_pkg::*;

  // error numerator 2*col - w, signed, and derived datapath widths
  localparam int NUM_W   = ((COORD_BITS + 1 > IMG_W) ? COORD_BITS + 1 : IMG_W) + 1;
  localparam int MAG_W   = NUM_W - 1;
  localparam int EXM_W   = COORD_BITS + 15;
  localparam int STEER_W = GAIN_W + EXM_W;
  localparam int SIDE_W  = STEER_W + 2;
  localparam int SPW_W   = SIDE_W - 30;

  // config registers
  logic [14:0]      thr_r;
  logic [IMG_W-1:0] img_w_r;
  logic [15:0]      fmin_r, fmax_r;
  logic [6:0]       spd_near_r, spd_far_r;
  logic [7:0]       gain_near_r, gain_far_r;

  // captured record
  logic                  found_r;
  logic [15:0]           score_r;
  logic [COORD_BITS-1:0] col_r, tw_r;
  logic [3:0]            key_r;

  // sequencer
  logic  busy_r, busy_nxt;
  step_t step_r, step_nxt;
  ucw_t  uc;
  logic  take;

  // datapath
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [VB_W-1:0]    vb_r, vb_nxt;
  logic [GAIN_W-1:0]  gain_r, gain_nxt;
  logic [BETA_W-1:0]  beta_r, beta_nxt;
  logic               neg_r, neg_nxt;
  logic [STEER_W-1:0] steer_r, steer_nxt;
  logic [6:0]         li_r, li_nxt, ri_r, ri_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [FILT_W-1:0]  lf_r, lf_nxt, rf_r, rf_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [6:0] out_lp_r, out_lp_nxt, out_rp_r, out_rp_nxt;
  logic       out_ov_r, out_ov_nxt;
  logic [3:0] out_key_r, out_key_nxt;

  // divider hookup
  logic             div_start;
  logic [DIV_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy;
  logic [DIV_W-1:0] div_q;

  // combinational helpers
  logic               accept;
  logic               alpha_nodiv;
  logic               out_held;
  logic [IMG_W-1:0]   w_eff;
  logic [NUM_W-1:0]   num;
  logic [MAG_W-1:0]   mag;
  logic [15:0]        na;
  logic [29:0]        bsum;
  logic [SIDE_W-1:0]  vb_sh;
  logic [EMA_W-1:0]   ema_sum_l, ema_sum_r;
  logic [38:0]        dec_l, dec_r;

  // power of one side, Q.30 -> 0..100 rounded half up
  function automatic logic [6:0] side_pow(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] t;
    logic [SPW_W-1:0]  r;
    t = s + (SIDE_W'(1) << 29);
    r = t[SIDE_W-1:30];
    if (s[SIDE_W-1]) begin
      return 7'd0;
    end else if (r > SPW_W'(POWER_MAX)) begin
      return POWER_MAX;
    end
    return r[6:0];
  endfunction

  ads_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------------------
  // config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 15'd18022;
      img_w_r     <= 12'd320;
      fmin_r      <= 16'd3932;
      fmax_r      <= 16'd13107;
      spd_near_r  <= 7'd20;
      spd_far_r   <= 7'd80;
      gain_near_r <= 8'd20;
      gain_far_r  <= 8'd40;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCORE_THR: thr_r       <= cfg_data[14:0];
        REG_IMG_WIDTH: img_w_r     <= cfg_data[IMG_W-1:0];
        REG_FRAC_MIN:  fmin_r      <= cfg_data;
        REG_FRAC_MAX:  fmax_r      <= cfg_data;
        REG_SPD_NEAR:  spd_near_r  <= cfg_data[6:0];
        REG_SPD_FAR:   spd_far_r   <= cfg_data[6:0];
        REG_GAIN_NEAR: gain_near_r <= cfg_data[7:0];
        REG_GAIN_FAR:  gain_far_r  <= cfg_data[7:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input capture
  // ---------------------------------------------------------------------------
  assign in_stall = busy_r;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      found_r <= in_target_found;
      score_r <= in_match_score;
      col_r   <= in_target_column;
      tw_r    <= in_target_width;
      key_r   <= in_pressed_key;
    end
  end

  // ---------------------------------------------------------------------------
  // shared combinational terms
  // ---------------------------------------------------------------------------
  always_comb begin
    accept   = found_r && ($signed(score_r) >= $signed({1'b0, thr_r}));
    // zero width register behaves as one pixel
    w_eff    = (img_w_r == '0) ? IMG_W'(1) : img_w_r;
    num      = (NUM_W'(col_r) << 1) - NUM_W'(w_eff);
    mag      = num[NUM_W-1] ? MAG_W'(-num) : num[MAG_W-1:0];
    na       = Q15_ONE - alpha_r;
    bsum     = (30'(na) << 14) + 30'(alpha_r) * 30'(BETA_NEAR) + 30'(16384);
    vb_sh    = SIDE_W'(vb_r) << 15;
    out_held = out_valid_r && out_stall;
    ema_sum_l = EMA_W'(prod_r) + ((EMA_W'(beta_r) * EMA_W'(li_r)) << 16) + EMA_W'(16384);
    ema_sum_r = EMA_W'(prod_r) + ((EMA_W'(beta_r) * EMA_W'(ri_r)) << 16) + EMA_W'(16384);
    dec_l    = 39'(lf_r) * 39'(DECAY_Q15);
    dec_r    = 39'(rf_r) * 39'(DECAY_Q15);
  end

  // ---------------------------------------------------------------------------
  // datapath, driven by the current control word
  // ---------------------------------------------------------------------------
  assign uc = ucode(step_r);

  always_comb begin
    alpha_nxt     = alpha_r;
    vb_nxt        = vb_r;
    gain_nxt      = gain_r;
    beta_nxt      = beta_r;
    neg_nxt       = neg_r;
    steer_nxt     = steer_r;
    li_nxt        = li_r;
    ri_nxt        = ri_r;
    prod_nxt      = prod_r;
    lf_nxt        = lf_r;
    rf_nxt        = rf_r;
    out_valid_nxt = out_held;
    out_lp_nxt    = out_lp_r;
    out_rp_nxt    = out_rp_r;
    out_ov_nxt    = out_ov_r;
    out_key_nxt   = out_key_r;
    div_start     = 1'b0;
    div_dvd       = DIV_W'(tw_r) << 16;
    div_dvs       = DVS_W'(w_eff);
    alpha_nodiv   = 1'b1;

    if (busy_r) begin
      unique case (uc.op)
        OP_NOP: ;
        OP_FRAC: begin
          // frac = tw * 65536 / w
          div_start = 1'b1;
        end
        OP_ALPHA: begin
          if (div_q <= DIV_W'(fmin_r)) begin
            alpha_nxt = '0;
          end else if (div_q >= DIV_W'(fmax_r)) begin
            alpha_nxt = Q15_ONE;
          end else begin
            // strictly inside the band: (frac - min) * 32768 / (max - min)
            alpha_nodiv = 1'b0;
            div_start   = 1'b1;
            div_dvd     = DIV_W'(div_q[15:0] - fmin_r) << 15;
            div_dvs     = fmax_r - fmin_r;
          end
        end
        OP_ALPHA_Q: alpha_nxt = div_q[ALPHA_W-1:0];
        OP_EX: begin
          // |2*col - w| * 32768 / (2*w), sign kept aside
          div_start = 1'b1;
          div_dvd   = DIV_W'(mag) << 15;
          div_dvs   = DVS_W'({w_eff, 1'b0});
          neg_nxt   = num[NUM_W-1];
        end
        OP_VB: begin
          vb_nxt = VB_W'(na) * VB_W'(spd_far_r) + VB_W'(alpha_r) * VB_W'(spd_near_r);
        end
        OP_GAIN: begin
          gain_nxt = GAIN_W'(na) * GAIN_W'(gain_far_r) + GAIN_W'(alpha_r) * GAIN_W'(gain_near_r);
        end
        OP_BETA: beta_nxt = bsum[29:15];
        OP_STEER: begin
          steer_nxt = STEER_W'(gain_r) * STEER_W'(div_q[EXM_W-1:0]);
        end
        OP_SIDE_L: begin
          li_nxt = side_pow(neg_r ? vb_sh - SIDE_W'(steer_r) : vb_sh + SIDE_W'(steer_r));
        end
        OP_SIDE_R: begin
          ri_nxt = side_pow(neg_r ? vb_sh + SIDE_W'(steer_r) : vb_sh - SIDE_W'(steer_r));
        end
        OP_EMA_L1: prod_nxt = PROD_W'(Q15_ONE - 16'(beta_r)) * PROD_W'(lf_r);
        OP_EMA_L2: lf_nxt = ema_sum_l[FILT_W+14:15];
        OP_EMA_R1: prod_nxt = PROD_W'(Q15_ONE - 16'(beta_r)) * PROD_W'(rf_r);
        OP_EMA_R2: rf_nxt = ema_sum_r[FILT_W+14:15];
        OP_DECAY_L: lf_nxt = dec_l[FILT_W+14:15];
        OP_DECAY_R: rf_nxt = dec_r[FILT_W+14:15];
        OP_OUT: begin
          if (!out_held) begin
            out_valid_nxt = 1'b1;
            out_lp_nxt    = filt_out(lf_r);
            out_rp_nxt    = filt_out(rf_r);
            out_ov_nxt    = (key_r >= 4'd1) && (key_r <= 4'd9);
            out_key_nxt   = out_ov_nxt ? key_r : 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: step counter with conditional jumps
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (uc.cond)
      COND_NONE:     take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_REJECT:   take = !accept;
      COND_DIV_BUSY: take = div_busy;
      COND_NO_DIV:   take = alpha_nodiv;
      COND_OUT_HELD: take = out_held;
      default:       take = 1'b0;
    endcase

    busy_nxt = busy_r;
    step_nxt = step_r;
    if (busy_r) begin
      priority if (take) begin
        step_nxt = uc.target;
      end else if (uc.last) begin
        busy_nxt = 1'b0;
        step_nxt = ST_CHECK;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end else if (in_valid) begin
      busy_nxt = 1'b1;
      step_nxt = ST_CHECK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_CHECK;
      out_valid_r <= 1'b0;
      lf_r        <= '0;
      rf_r        <= '0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      lf_r        <= lf_nxt;
      rf_r        <= rf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alpha_r   <= alpha_nxt;
    vb_r      <= vb_nxt;
    gain_r    <= gain_nxt;
    beta_r    <= beta_nxt;
    neg_r     <= neg_nxt;
    steer_r   <= steer_nxt;
    li_r      <= li_nxt;
    ri_r      <= ri_nxt;
    prod_r    <= prod_nxt;
    out_lp_r  <= out_lp_nxt;
    out_rp_r  <= out_rp_nxt;
    out_ov_r  <= out_ov_nxt;
    out_key_r <= out_key_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_left_power      = out_lp_r;
  assign out_right_power     = out_rp_r;
  assign out_override_active = out_ov_r;
  assign out_override_key    = out_key_r;

`ifndef ASSERT_OFF
  // a transfer starts the program at its first step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> busy_r && step_r == ST_CHECK)
    else $error("record taken but program not started");

  // the shared divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // program counter stays inside the ROM program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> step_r <= ST_OUT)
    else $error("step counter out of program");

  // powers are capped
  a_power_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_lp_r <= POWER_MAX && out_rp_r <= POWER_MAX)
    else $error("motor power above cap");

  // key only passes through when override is flagged
  a_key_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ov_r |-> out_key_r == 4'd0)
    else $error("override key without override");
`endif

endmodule
`default_nettype wire
